// File: rtl/snappy_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snappy_pkg: shared constants and types
// phase codes and the copy request passed from parser to copy engine
// ----------------------------------------------------------------------------
package snappy_pkg;

  localparam int unsigned HistDepthDefault = 65536;

  // parse phase codes
  localparam logic [2:0] PhHeader  = 3'd0;
  localparam logic [2:0] PhTag     = 3'd1;
  localparam logic [2:0] PhLitLen  = 3'd2;
  localparam logic [2:0] PhLitData = 3'd3;
  localparam logic [2:0] PhCopyOff = 3'd4;

  // tag kinds
  localparam logic [1:0] TagLiteral = 2'd0;
  localparam logic [1:0] TagCopy1   = 2'd1;
  localparam logic [1:0] TagCopy2   = 2'd2;
  localparam logic [1:0] TagCopy4   = 2'd3;

  // copy request from parser
  typedef struct packed {
    logic        start;
    logic [6:0]  length;
    logic [31:0] offset;
  } copy_req_t;

endpackage

// File: rtl/snappy_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snappy_ram: generic single port ram
// one address a cycle, read every cycle and written when we_i is set; registered read data
// ----------------------------------------------------------------------------
module snappy_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // storage and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// File: rtl/snappy_block_decompressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snappy_block_decompressor: raw snappy block decoder
// byte-wide stream in, decompressed bytes out, history in a single port ram
// ----------------------------------------------------------------------------
// usage
//   s_axis: one compressed byte a transaction, tuser marks a stream start.
//   m_axis: one decompressed byte a transaction, tlast on the last result
//   caused by one input byte, tuser carries the bad offset flag.
//   header and tag bytes give no result.
//   a literal byte is presented in the cycle after it is taken.
//   in a copy of n bytes, each byte is one read and one write of the single
//   port history ram, sequenced by the copy engine.
//   a bad offset gives one error result, no history access.
//   s_axis_tready is low while a result waits or a copy runs; a stalled
//   receiver holds the output register and the sequencer.
//   reset clears the parser and counters; history content is undefined and
//   is only read where it was written in this stream.
// ----------------------------------------------------------------------------
module snappy_block_decompressor #(
  parameter int unsigned HistoryDepth = snappy_pkg::HistDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  input  logic        s_axis_tuser,   // stream_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_byte, declared_size, 8 zero bits
  output logic        m_axis_tlast,   // last_of_run
  output logic        m_axis_tuser    // bad_offset
);

  localparam int unsigned Aw = $clog2(HistoryDepth);

  // sequencer codes
  localparam logic [1:0] SqIdle = 2'd0;
  localparam logic [1:0] SqRead = 2'd1;
  localparam logic [1:0] SqWait = 2'd2;
  localparam logic [1:0] SqOut  = 2'd3;

  logic [2:0]  phase_q, phase_d;
  logic [2:0]  grp_q, grp_d;
  logic [31:0] size_q, size_d;
  logic [1:0]  kind_q, kind_d;
  logic [2:0]  extra_q, extra_d;
  logic [32:0] lit_q, lit_d;
  logic [6:0]  clen_q, clen_d;
  logic [31:0] coff_q, coff_d;
  logic [5:0]  xsh_q, xsh_d;
  logic [Aw-1:0] wp_q, wp_d;
  logic [31:0] bw_q, bw_d;
  logic [1:0]  sq_q, sq_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        ov_q, ov_d;
  logic [7:0]  ob_q, ob_d;
  logic        ol_q, ol_d, obad_q, obad_d;

  logic        acc, we;
  logic [Aw-1:0] addr;
  logic [7:0]  wdata, rdata;
  logic [7:0]  b, v;
  logic [2:0]  ph, grp;
  logic [31:0] sz, bw;
  logic [Aw-1:0] wp;
  logic [5:0]  sh;
  logic        st;
  snappy_pkg::copy_req_t req;

  assign acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !ov_q && (sq_q == SqIdle);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {8'd0, size_q, ob_q};
  assign m_axis_tlast  = ol_q;
  assign m_axis_tuser  = obad_q;
  assign b = s_axis_tdata;
  assign v = {2'b00, b[7:2]};

  snappy_ram #(.Width(8), .Depth(HistoryDepth)) u_hist (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  // parser and copy sequencer
  always_comb begin
    phase_d = phase_q; grp_d = grp_q; size_d = size_q; kind_d = kind_q;
    extra_d = extra_q; lit_d = lit_q; clen_d = clen_q; coff_d = coff_q;
    xsh_d = xsh_q; wp_d = wp_q; bw_d = bw_q; sq_d = sq_q; cnt_d = cnt_q;
    ov_d = ov_q; ob_d = ob_q; ol_d = ol_q; obad_d = obad_q;
    we = 1'b0; wdata = b; addr = wp_q - coff_q[Aw-1:0];
    req = '0;
    st = acc && s_axis_tuser;
    ph = st ? snappy_pkg::PhHeader : phase_q;
    grp = st ? 3'd0 : grp_q;
    sz = st ? 32'd0 : size_q;
    bw = st ? 32'd0 : bw_q;
    wp = st ? '0 : wp_q;
    sh = xsh_q;
    if (m_axis_tready && ov_q) ov_d = 1'b0;
    if (acc) begin
      phase_d = ph; grp_d = grp; size_d = sz; bw_d = bw; wp_d = wp;
      if (st) begin
        kind_d = '0; extra_d = '0; lit_d = '0; clen_d = '0; coff_d = '0;
        xsh_d = '0;
      end
      case (ph)
        snappy_pkg::PhHeader: begin
          if (grp < 3'd5) size_d = sz | ({25'd0, b[6:0]} << (7 * grp));
          if (grp != 3'd7) grp_d = grp + 3'd1;
          if (!b[7]) phase_d = snappy_pkg::PhTag;
        end
        snappy_pkg::PhTag: begin
          kind_d = b[1:0]; xsh_d = '0; coff_d = '0;
          if (b[1:0] == snappy_pkg::TagLiteral) begin
            if (v < 8'd60) begin
              lit_d = {25'd0, v} + 33'd1; phase_d = snappy_pkg::PhLitData;
            end else begin
              extra_d = 3'(v - 8'd59); lit_d = '0;
              phase_d = snappy_pkg::PhLitLen;
            end
          end else if (b[1:0] == snappy_pkg::TagCopy1) begin
            clen_d = {4'd0, v[2:0]} + 7'd4;
            coff_d = {21'd0, v[5:3], 8'd0};
            extra_d = 3'd1; phase_d = snappy_pkg::PhCopyOff;
          end else begin
            clen_d = {1'b0, v[5:0]} + 7'd1;
            extra_d = (b[1:0] == snappy_pkg::TagCopy2) ? 3'd2 : 3'd4;
            phase_d = snappy_pkg::PhCopyOff;
          end
        end
        snappy_pkg::PhLitLen: begin
          lit_d = lit_q | ({25'd0, b} << sh);
          xsh_d = sh + 6'd8; extra_d = extra_q - 3'd1;
          if (extra_q == 3'd1) begin
            lit_d = (lit_q | ({25'd0, b} << sh)) + 33'd1;
            phase_d = snappy_pkg::PhLitData;
          end
        end
        snappy_pkg::PhLitData: begin
          we = 1'b1; addr = wp_q; wp_d = wp_q + Aw'(1);
          if (bw_q != '1) bw_d = bw_q + 32'd1;
          ov_d = 1'b1; ob_d = b; ol_d = 1'b1; obad_d = 1'b0;
          lit_d = lit_q - 33'd1;
          if (lit_q == 33'd1) phase_d = snappy_pkg::PhTag;
        end
        snappy_pkg::PhCopyOff: begin
          if (kind_q == snappy_pkg::TagCopy1) coff_d = coff_q | {24'd0, b};
          else coff_d = coff_q | ({24'd0, b} << sh[4:0]);
          xsh_d = sh + 6'd8; extra_d = extra_q - 3'd1;
          if (extra_q == 3'd1) begin
            phase_d = snappy_pkg::PhTag;
            req.start = 1'b1; req.length = clen_q; req.offset = coff_d;
          end
        end
        default: phase_d = snappy_pkg::PhTag;
      endcase
      if (req.start) begin
        if (req.offset == 32'd0 || req.offset > bw_q ||
            req.offset > 32'(HistoryDepth)) begin
          ov_d = 1'b1; ob_d = 8'd0; ol_d = 1'b1; obad_d = 1'b1;
        end else begin
          sq_d = SqRead; cnt_d = req.length;
        end
      end
    end else begin
      case (sq_q)
        SqIdle: ;
        SqRead: if (!ov_q || m_axis_tready) sq_d = SqWait;
        SqWait: begin
          we = 1'b1; addr = wp_q; wdata = rdata; wp_d = wp_q + Aw'(1);
          if (bw_q != '1) bw_d = bw_q + 32'd1;
          ov_d = 1'b1; ob_d = rdata; obad_d = 1'b0; ol_d = (cnt_q == 7'd1);
          cnt_d = cnt_q - 7'd1;
          sq_d = (cnt_q == 7'd1) ? SqIdle : SqRead;
        end
        default: sq_d = SqIdle;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= snappy_pkg::PhHeader; grp_q <= '0; size_q <= '0; kind_q <= '0;
      extra_q <= '0; lit_q <= '0; clen_q <= '0; coff_q <= '0; xsh_q <= '0;
      wp_q <= '0; bw_q <= '0; sq_q <= SqIdle; cnt_q <= '0; ov_q <= 1'b0;
    end else begin
      phase_q <= phase_d; grp_q <= grp_d; size_q <= size_d; kind_q <= kind_d;
      extra_q <= extra_d; lit_q <= lit_d; clen_q <= clen_d; coff_q <= coff_d;
      xsh_q <= xsh_d; wp_q <= wp_d; bw_q <= bw_d; sq_q <= sq_d; cnt_q <= cnt_d;
      ov_q <= ov_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    ob_q <= ob_d; ol_q <= ol_d; obad_q <= obad_d;
  end

`ifndef SYNTH
  // an error result always closes its run
  a_bad_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("bad offset result without tlast");
  // no input taken while a copy runs
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_q != SqIdle |-> !s_axis_tready)
    else $error("ready during copy");
  // a copy never writes over a waiting result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result lost");
`endif

endmodule
